// File: rtl/core/dxt_pkg.sv
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, constants and fixed-divisor helpers for the BC1/BC3 decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

   localparam int MAX_DIMENSION = 4096;

   localparam int WORD_W  = 64;
   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int POS_W   = 10;
   localparam int GRID_W  = 11;
   localparam int CHAN_W  = 8;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd64;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd64;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // reciprocals for exact floor division over the operand ranges used here
   localparam logic [13:0] RECIP31 = 14'd8457;
   localparam int          RECIP31_SHIFT = 18;
   localparam logic [14:0] RECIP63 = 15'd16645;
   localparam int          RECIP63_SHIFT = 20;
   localparam logic [10:0] RECIP3  = 11'd1366;
   localparam int          RECIP3_SHIFT = 12;
   localparam logic [11:0] RECIP7  = 12'd2341;
   localparam logic [11:0] RECIP5  = 12'd3277;
   localparam int          RECIP57_SHIFT = 14;

   typedef struct packed {
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
      logic [2:0]         nx;
      logic [2:0]         ny;
      logic               final_block;
   } dxt_pos_type;

   // one decoded block waiting for texel emission
   typedef struct packed {
      logic [3:0][2:0][CHAN_W-1:0] palette;   // entry, channel (r g b)
      logic [7:0][CHAN_W-1:0]      ramp;
      logic [31:0]                 color_index;
      logic [47:0]                 alpha_index;
      logic                        dxt5;
      logic                        punch;
      dxt_pos_type                 pos;
   } dxt_block_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      logic               last_of_block;
      logic               last_of_surface;
   } dxt_texel_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

   // (x*255 + 15) / 31
   function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] x);
      logic [12:0] v;
      logic [26:0] p;
      v = {x, 8'd0} - 13'(x) + 13'd15;
      p = 27'(v) * 27'(RECIP31);
      return p[RECIP31_SHIFT +: CHAN_W];
   endfunction

   // (x*255 + 31) / 63
   function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] x);
      logic [13:0] v;
      logic [28:0] p;
      v = {x, 8'd0} - 14'(x) + 14'd31;
      p = 29'(v) * 29'(RECIP63);
      return p[RECIP63_SHIFT +: CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] div3(input logic [9:0] v);
      logic [20:0] p;
      p = 21'(v) * 21'(RECIP3);
      return p[RECIP3_SHIFT +: CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] div7(input logic [10:0] v);
      logic [22:0] p;
      p = 23'(v) * 23'(RECIP7);
      return p[RECIP57_SHIFT +: CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] div5(input logic [10:0] v);
      logic [22:0] p;
      p = 23'(v) * 23'(RECIP5);
      return p[RECIP57_SHIFT +: CHAN_W];
   endfunction

endpackage

// File: rtl/core/dxt_if.sv
// ----------------------------------------------------------------------------
// dxt channel interfaces
// Block input, texel output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface dxt_req_if import dxt_pkg::*;;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] color_word;
   logic [WORD_W-1:0] alpha_word;

   modport source (output valid, output color_word, output alpha_word, input ready);
   modport sink (input valid, input color_word, input alpha_word, output ready);
endinterface

interface dxt_rsp_if import dxt_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;
   logic [CHAN_W-1:0]  alpha;
   logic               last_of_block;
   logic               last_of_surface;

   modport source (output valid, output pixel_x, output pixel_y, output red, output green,
                   output blue, output alpha, output last_of_block, output last_of_surface,
                   input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input red, input green,
                 input blue, input alpha, input last_of_block, input last_of_surface,
                 output ready);
endinterface

interface dxt_csr_if import dxt_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DIM_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/dxt_front.sv
// ----------------------------------------------------------------------------
// dxt_front
// Accepts blocks, tracks block position and clipping, builds palette and ramp.
// ----------------------------------------------------------------------------
module dxt_front import dxt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   dxt_req_if.sink       req_chan,
   dxt_csr_if.sink       csr_chan,
   output logic          push_valid,
   input  logic          push_ready,
   output dxt_block_type push_entry
);

   // configuration and block position
   logic             alpha_mode_ff, alpha_mode_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;

   // stage a: raw words plus position
   logic              a_valid_ff, a_valid_in;
   logic [WORD_W-1:0] a_color_ff, a_color_in;
   logic [WORD_W-1:0] a_alpha_ff, a_alpha_in;
   logic              a_dxt5_ff, a_dxt5_in;
   dxt_pos_type       a_pos_ff, a_pos_in;

   // stage b: expanded endpoints and ramp numerators
   logic                        b_valid_ff, b_valid_in;
   logic [1:0][2:0][CHAN_W-1:0] b_color_ff, b_color_in;
   logic [5:0][10:0]            b_num_ff, b_num_in;
   logic                        b_six_ff, b_six_in;
   logic [CHAN_W-1:0]           b_a0_ff, b_a0_in;
   logic [CHAN_W-1:0]           b_a1_ff, b_a1_in;
   logic [31:0]                 b_cidx_ff, b_cidx_in;
   logic [47:0]                 b_aidx_ff, b_aidx_in;
   logic                        b_dxt5_ff, b_dxt5_in;
   logic                        b_punch_ff, b_punch_in;
   dxt_pos_type                 b_pos_ff, b_pos_in;

   logic              accept, a_moves, b_free;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [13:0]       w_sum, h_sum;
   logic [GRID_W-1:0] cols, rows, col_plus, row_plus;
   logic              in_grid;
   logic [DIM_W-1:0]  rem_x, rem_y;
   logic [15:0]       e0, e1;

   assign csr_chan.ready = 1'b1;

   assign b_free  = !b_valid_ff || push_ready;
   assign a_moves = a_valid_ff && b_free;
   assign req_chan.ready = !a_valid_ff || a_moves;
   assign accept  = req_chan.valid && req_chan.ready;

   // surface geometry from the current registers
   always_comb begin
      w_eff    = clamp_dim(width_ff);
      h_eff    = clamp_dim(height_ff);
      w_sum    = 14'(w_eff) + 14'd3;
      h_sum    = 14'(h_eff) + 14'd3;
      cols     = w_sum[12:2];
      rows     = h_sum[12:2];
      col_plus = GRID_W'(col_ff) + GRID_W'(1);
      row_plus = GRID_W'(row_ff) + GRID_W'(1);
      in_grid  = (GRID_W'(col_ff) < cols) && (GRID_W'(row_ff) < rows);
      rem_x    = w_eff - DIM_W'({col_ff, 2'b00});
      rem_y    = h_eff - DIM_W'({row_ff, 2'b00});
   end

   always_comb begin
      alpha_mode_in = alpha_mode_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ALPHA_MODE:   alpha_mode_in = csr_chan.data[0];
            CSR_IMAGE_WIDTH:  width_in      = csr_chan.data;
            CSR_IMAGE_HEIGHT: height_in     = csr_chan.data;
            default: ;
         endcase
      end
   end

   // block advance happens for every item, including those outside the grid
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_plus >= cols) begin
            col_in = '0;
            if (row_plus >= rows) row_in = '0;
            else row_in = row_plus[POS_W-1:0];
         end else begin
            col_in = col_plus[POS_W-1:0];
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) a_valid_in = in_grid;
      else if (a_moves) a_valid_in = 1'b0;
      a_color_in = accept ? req_chan.color_word : a_color_ff;
      a_alpha_in = accept ? req_chan.alpha_word : a_alpha_ff;
      a_dxt5_in  = accept ? alpha_mode_ff : a_dxt5_ff;
      a_pos_in   = a_pos_ff;
      if (accept) begin
         a_pos_in.bx          = {col_ff, 2'b00};
         a_pos_in.by          = {row_ff, 2'b00};
         a_pos_in.nx          = (rem_x > DIM_W'(3)) ? 3'd4 : rem_x[2:0];
         a_pos_in.ny          = (rem_y > DIM_W'(3)) ? 3'd4 : rem_y[2:0];
         a_pos_in.final_block = (col_plus == cols) && (row_plus == rows);
      end
   end

   // stage b logic
   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_moves) b_valid_in = 1'b1;
      else if (push_ready) b_valid_in = 1'b0;

      e0 = a_color_ff[15:0];
      e1 = a_color_ff[31:16];

      b_color_in = b_color_ff;
      b_num_in   = b_num_ff;
      b_six_in   = b_six_ff;
      b_a0_in    = b_a0_ff;
      b_a1_in    = b_a1_ff;
      b_cidx_in  = b_cidx_ff;
      b_aidx_in  = b_aidx_ff;
      b_dxt5_in  = b_dxt5_ff;
      b_punch_in = b_punch_ff;
      b_pos_in   = b_pos_ff;
      if (a_moves) begin
         b_color_in[0][0] = expand5(e0[15:11]);
         b_color_in[0][1] = expand6(e0[10:5]);
         b_color_in[0][2] = expand5(e0[4:0]);
         b_color_in[1][0] = expand5(e1[15:11]);
         b_color_in[1][1] = expand6(e1[10:5]);
         b_color_in[1][2] = expand5(e1[4:0]);
         b_a0_in  = a_alpha_ff[7:0];
         b_a1_in  = a_alpha_ff[15:8];
         b_six_in = a_alpha_ff[7:0] > a_alpha_ff[15:8];
         for (int k = 0; k < 6; k++) begin
            if (a_alpha_ff[7:0] > a_alpha_ff[15:8])
               b_num_in[k] = 11'(a_alpha_ff[7:0]) * 11'(6 - k)
                           + 11'(a_alpha_ff[15:8]) * 11'(k + 1);
            else
               b_num_in[k] = 11'(a_alpha_ff[7:0]) * 11'((4 - k) & 7)
                           + 11'(a_alpha_ff[15:8]) * 11'(k + 1);
         end
         b_cidx_in  = a_color_ff[63:32];
         b_aidx_in  = a_alpha_ff[63:16];
         b_dxt5_in  = a_dxt5_ff;
         b_punch_in = !a_dxt5_ff && (e0 <= e1);
         b_pos_in   = a_pos_ff;
      end
   end

   // palette blend and ramp division feed the queue directly
   always_comb begin
      push_entry = '0;
      for (int ch = 0; ch < 3; ch++) begin
         push_entry.palette[0][ch] = b_color_ff[0][ch];
         push_entry.palette[1][ch] = b_color_ff[1][ch];
         if (b_punch_ff) begin
            push_entry.palette[2][ch] =
               8'((9'(b_color_ff[0][ch]) + 9'(b_color_ff[1][ch])) >> 1);
            push_entry.palette[3][ch] = '0;
         end else begin
            push_entry.palette[2][ch] =
               div3({1'b0, b_color_ff[0][ch], 1'b0} + 10'(b_color_ff[1][ch]));
            push_entry.palette[3][ch] =
               div3(10'(b_color_ff[0][ch]) + {1'b0, b_color_ff[1][ch], 1'b0});
         end
      end
      push_entry.ramp[0] = b_a0_ff;
      push_entry.ramp[1] = b_a1_ff;
      for (int k = 0; k < 6; k++) begin
         if (b_six_ff) push_entry.ramp[k + 2] = div7(b_num_ff[k]);
         else if (k < 4) push_entry.ramp[k + 2] = div5(b_num_ff[k]);
         else if (k == 4) push_entry.ramp[k + 2] = ALPHA_CLEAR;
         else push_entry.ramp[k + 2] = ALPHA_OPAQUE;
      end
      push_entry.color_index = b_cidx_ff;
      push_entry.alpha_index = b_aidx_ff;
      push_entry.dxt5        = b_dxt5_ff;
      push_entry.punch       = b_punch_ff;
      push_entry.pos         = b_pos_ff;
   end

   assign push_valid = b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_mode_ff <= 1'b0;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         alpha_mode_ff <= alpha_mode_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_color_ff <= a_color_in;
      a_alpha_ff <= a_alpha_in;
      a_dxt5_ff  <= a_dxt5_in;
      a_pos_ff   <= a_pos_in;
      b_color_ff <= b_color_in;
      b_num_ff   <= b_num_in;
      b_six_ff   <= b_six_in;
      b_a0_ff    <= b_a0_in;
      b_a1_ff    <= b_a1_in;
      b_cidx_ff  <= b_cidx_in;
      b_aidx_ff  <= b_aidx_in;
      b_dxt5_ff  <= b_dxt5_in;
      b_punch_ff <= b_punch_in;
      b_pos_ff   <= b_pos_in;
   end

endmodule

// File: rtl/core/dxt_queue.sv
// ----------------------------------------------------------------------------
// dxt_queue
// Short queue of decoded blocks between the front and the texel sequencer.
// ----------------------------------------------------------------------------
module dxt_queue import dxt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  dxt_block_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output dxt_block_type pop_entry
);

   dxt_block_type [QUEUE_DEPTH-1:0] slot_ff, slot_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_entry;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// File: rtl/core/dxt_back.sv
// ----------------------------------------------------------------------------
// dxt_back
// Walks the texels of the head block in raster order, one per cycle unless rsp_chan stalls.
// ----------------------------------------------------------------------------
module dxt_back import dxt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  dxt_block_type head,
   output logic          pop,
   dxt_rsp_if.source     rsp_chan
);

   logic [1:0]    tx_ff, tx_in;
   logic [1:0]    ty_ff, ty_in;
   logic          out_valid_ff, out_valid_in;
   dxt_texel_type out_ff, out_in;

   logic       emit, last_x, last_y;
   logic [3:0] texel;
   logic [1:0] ci;
   logic [2:0] ai;
   logic [5:0] ai_base;

   assign emit    = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign texel   = {ty_ff, tx_ff};
   assign ai_base = 6'({texel, 1'b0}) + 6'(texel);
   assign ci      = head.color_index[{texel, 1'b0} +: 2];
   assign ai      = head.alpha_index[ai_base +: 3];
   assign last_x  = {1'b0, tx_ff} == head.pos.nx - 3'd1;
   assign last_y  = {1'b0, ty_ff} == head.pos.ny - 3'd1;
   assign pop     = emit && last_x && last_y;

   always_comb begin
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         if (last_x) begin
            tx_in = '0;
            ty_in = last_y ? 2'd0 : ty_ff + 2'd1;
         end else begin
            tx_in = tx_ff + 2'd1;
         end
         out_in.pixel_x = head.pos.bx + COORD_W'(tx_ff);
         out_in.pixel_y = head.pos.by + COORD_W'(ty_ff);
         out_in.red     = head.palette[ci][0];
         out_in.green   = head.palette[ci][1];
         out_in.blue    = head.palette[ci][2];
         if (head.dxt5) out_in.alpha = head.ramp[ai];
         else if (head.punch && ci == 2'd3) out_in.alpha = ALPHA_CLEAR;
         else out_in.alpha = ALPHA_OPAQUE;
         out_in.last_of_block   = last_x && last_y;
         out_in.last_of_surface = last_x && last_y && head.pos.final_block;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.pixel_x         = out_ff.pixel_x;
   assign rsp_chan.pixel_y         = out_ff.pixel_y;
   assign rsp_chan.red             = out_ff.red;
   assign rsp_chan.green           = out_ff.green;
   assign rsp_chan.blue            = out_ff.blue;
   assign rsp_chan.alpha           = out_ff.alpha;
   assign rsp_chan.last_of_block   = out_ff.last_of_block;
   assign rsp_chan.last_of_surface = out_ff.last_of_surface;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff        <= '0;
         ty_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// File: rtl/core/dxt1_dxt5_block_decoder.sv
// ----------------------------------------------------------------------------
// dxt1_dxt5_block_decoder
// BC1/BC3 block decoder: one compressed 4x4 block in, up to 16 texels out.
// ----------------------------------------------------------------------------
// req_chan takes one block per item (color_word, alpha_word) in raster block
// order; rsp_chan gives one texel per item with its surface coordinates,
// last_of_block on the final texel of a block and last_of_surface on the
// final texel of the last block. csr_chan writes alpha_mode, image_width and
// image_height; it is always ready and must be written only while idle;
// the block itself does not enforce this. A block accepted on req_chan
// passes through stage a, stage b, a queue slot and the texel output register
// before its first texel appears on rsp_chan. The texel sequencer emits one
// texel per cycle while rsp_chan is not stalled, and emits only the visible
// texels of clipped edge blocks. A block outside the grid produces no texels.
// The front accepts a block per cycle into a two-stage decode pipe and a
// two-block queue; it stalls only when both are full.
// Reset clears the block position to 0,0, the registers to DXT1 mode and a
// 64 x 64 surface, and empties the pipe, queue and output register.
// When the receiver stalls, the held texel stays on rsp_chan, the queue
// fills and req_chan.ready drops once there is no room left.
// ----------------------------------------------------------------------------
module dxt1_dxt5_block_decoder import dxt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dxt_req_if.sink    req_chan,
   dxt_rsp_if.source  rsp_chan,
   dxt_csr_if.sink    csr_chan
);

   logic          push_valid, push_ready;
   dxt_block_type push_entry;
   logic          head_valid, pop;
   dxt_block_type head;

   dxt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   dxt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop_ready  (pop),
      .pop_entry  (head)
   );

   dxt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: dv/tb_dxt1_dxt5_block_decoder.sv
// ----------------------------------------------------------------------------
// tb_dxt1_dxt5_block_decoder
// Drives compressed 4x4 blocks into the BC1/BC3 decoder under several surface
// sizes and both alpha modes, predicts every texel in a scoreboard and checks
// the texel stream in order, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_dxt1_dxt5_block_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import dxt_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_BLOCKS = 215;

   typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_pattern_type;

   // predicts the texel stream of the decoder and checks it in order
   class texel_scoreboard;
      bit                 dxt5_mode;
      logic [DIM_W-1:0]   width_reg;
      logic [DIM_W-1:0]   height_reg;
      logic [GRID_W-1:0]  column;
      logic [GRID_W-1:0]  row;
      dxt_texel_type      expected_q[$];
      int                 errors;

      function new();
         dxt5_mode = 1'b0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         column = '0;
         row = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [DIM_W-1:0] data);
         case (index)
            CSR_ALPHA_MODE: dxt5_mode = data[0];
            CSR_IMAGE_WIDTH: width_reg = data;
            CSR_IMAGE_HEIGHT: height_reg = data;
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(logic [DIM_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_DIMENSION) return MAX_DIMENSION;
         return v;
      endfunction

      function int unsigned expand_chan(logic [15:0] e, int c);
         case (c)
            0: return (int'(e[15:11]) * 255 + 15) / 31;
            1: return (int'(e[10:5]) * 255 + 31) / 63;
            default: return (int'(e[4:0]) * 255 + 15) / 31;
         endcase
      endfunction

      // returns the number of texels the block produces
      function int note_block(logic [WORD_W-1:0] cw, logic [WORD_W-1:0] aw);
         int unsigned   w, h, cols, rows, px, py, p0, p1, t;
         int unsigned   pal[4][3];
         int unsigned   pal_alpha[4];
         int unsigned   ramp[8];
         bit            four_color, final_blk;
         int            n;
         dxt_texel_type texels[16];
         logic [1:0]    sel;

         w = clamp_size(width_reg);
         h = clamp_size(height_reg);
         cols = (w + 3) / 4;
         rows = (h + 3) / 4;
         four_color = dxt5_mode || (cw[15:0] > cw[31:16]);
         final_blk = (column + 1 == cols) && (row + 1 == rows);
         n = 0;

         for (int c = 0; c < 3; c++) begin
            p0 = expand_chan(cw[15:0], c);
            p1 = expand_chan(cw[31:16], c);
            pal[0][c] = p0;
            pal[1][c] = p1;
            if (four_color) begin
               pal[2][c] = (2 * p0 + p1) / 3;
               pal[3][c] = (p0 + 2 * p1) / 3;
            end else begin
               pal[2][c] = (p0 + p1) / 2;
               pal[3][c] = 0;
            end
         end
         pal_alpha = '{255, 255, 255, 255};
         if (!four_color) pal_alpha[3] = 0;

         ramp[0] = aw[7:0];
         ramp[1] = aw[15:8];
         if (ramp[0] > ramp[1]) begin
            for (int s = 1; s < 7; s++) ramp[s + 1] = ((7 - s) * ramp[0] + s * ramp[1]) / 7;
         end else begin
            for (int s = 1; s < 5; s++) ramp[s + 1] = ((5 - s) * ramp[0] + s * ramp[1]) / 5;
            ramp[6] = 0;
            ramp[7] = 255;
         end

         if (column < cols && row < rows) begin
            for (int ty = 0; ty < 4; ty++) begin
               py = row * 4 + ty;
               if (py >= h) break;
               for (int tx = 0; tx < 4; tx++) begin
                  px = column * 4 + tx;
                  if (px >= w) break;
                  t = ty * 4 + tx;
                  sel = cw[32 + 2 * t +: 2];
                  texels[n].pixel_x = COORD_W'(px);
                  texels[n].pixel_y = COORD_W'(py);
                  texels[n].red = CHAN_W'(pal[sel][0]);
                  texels[n].green = CHAN_W'(pal[sel][1]);
                  texels[n].blue = CHAN_W'(pal[sel][2]);
                  texels[n].alpha = dxt5_mode ? CHAN_W'(ramp[aw[16 + 3 * t +: 3]])
                                              : CHAN_W'(pal_alpha[sel]);
                  texels[n].last_of_block = 1'b0;
                  texels[n].last_of_surface = 1'b0;
                  n++;
               end
            end
            if (n > 0) begin
               texels[n - 1].last_of_block = 1'b1;
               texels[n - 1].last_of_surface = final_blk;
            end
            for (int i = 0; i < n; i++) expected_q.push_back(texels[i]);
         end

         column++;
         if (column >= cols) begin
            column = '0;
            row++;
            if (row >= rows) row = '0;
         end
         return n;
      endfunction

      function void check_field(string name, int unsigned exp, int unsigned act,
                                dxt_texel_type e);
         if (exp != act) begin
            errors++;
            $display("%0t texel (%0d,%0d) %s mismatch: expected %0d actual %0d",
                     $time, e.pixel_x, e.pixel_y, name, exp, act);
         end
      endfunction

      function void check_texel(dxt_texel_type got);
         dxt_texel_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected texel: expected none actual x=%0d y=%0d rgba=%0d,%0d,%0d,%0d",
                     $time, got.pixel_x, got.pixel_y, got.red, got.green, got.blue, got.alpha);
            return;
         end
         e = expected_q.pop_front();
         check_field("pixel_x", e.pixel_x, got.pixel_x, e);
         check_field("pixel_y", e.pixel_y, got.pixel_y, e);
         check_field("red", e.red, got.red, e);
         check_field("green", e.green, got.green, e);
         check_field("blue", e.blue, got.blue, e);
         check_field("alpha", e.alpha, got.alpha, e);
         check_field("last_of_block", e.last_of_block, got.last_of_block, e);
         check_field("last_of_surface", e.last_of_surface, got.last_of_surface, e);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   texel_blocks;
   int   burst_left;
   bit   hold_req;

   texel_scoreboard sb = new();

   dxt_req_if req_chan();
   dxt_rsp_if rsp_chan();
   dxt_csr_if csr_chan();

   dxt1_dxt5_block_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (sb.note_block(req_chan.color_word, req_chan.alpha_word) > 0)
               texel_blocks++;
         end
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_texel('{rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.red,
                             rsp_chan.green, rsp_chan.blue, rsp_chan.alpha,
                             rsp_chan.last_of_block, rsp_chan.last_of_surface});
      end
   end

   // texel receiver: switches at random among free, mostly-ready, sparse and toggling stall patterns
   initial begin
      rx_pattern_type pattern;
      int             pattern_left;
      rsp_chan.ready = 1'b0;
      pattern = RX_FREE;
      pattern_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_chan.ready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern = rx_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (pattern)
               RX_FREE: rsp_chan.ready <= 1'b1;
               RX_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   // called at a falling edge; returns at a falling edge after the accept
   task automatic send_block(input logic [WORD_W-1:0] cw, input logic [WORD_W-1:0] aw);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_chan.valid <= 1'b1;
      req_chan.color_word <= cw;
      req_chan.alpha_word <= aw;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [DIM_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   // drop the input and let every outstanding texel drain
   task automatic settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input bit mode, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
      settle();
      write_csr(CSR_ALPHA_MODE, {(DIM_W-1)'($urandom), mode});
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   // alpha word whose texel t uses ramp entry t mod 8
   function automatic logic [WORD_W-1:0] ramp_walk(logic [7:0] a0, logic [7:0] a1);
      logic [WORD_W-1:0] aw;
      aw = {48'd0, a1, a0};
      for (int t = 0; t < 16; t++) aw[16 + 3 * t +: 3] = 3'(t % 8);
      return aw;
   endfunction

   function automatic logic [DIM_W-1:0] pick_size();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return DIM_W'($urandom_range(MAX_DIMENSION + 1, 8191));
         2: return DIM_MAX;
         3: return DIM_W'($urandom_range(1, MAX_DIMENSION));
         4: return 13'h1fff;
         default: return DIM_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_color();
      logic [WORD_W-1:0] cw;
      cw = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) cw[31:16] = cw[15:0];
      return cw;
   endfunction

   initial begin
      bit first_phase;
      int count;

      reset = 1'b1;
      cycle_count = 0;
      texel_blocks = 0;
      burst_left = 0;
      hold_req = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.color_word = '0;
      req_chan.alpha_word = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_ALPHA_MODE;
      csr_chan.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // dxt1 at the reset surface: four-colour, punch-through, equal endpoints
      send_block(64'hE4E4E4E4_0000FFFF, '0);
      send_block(64'hE4E4E4E4_FFFF0000, '1);
      send_block(64'hE4E4E4E4_7BEF7BEF, '0);
      send_block(64'h1B1B1B1B_07E0F800, '0);
      send_block('0, '0);
      send_block('1, '1);

      // dxt5: eight-step and six-step ramps, flat ramp, dxt5 with e0 < e1
      settle();
      write_csr(CSR_ALPHA_MODE, 13'd1);
      send_block(64'hE4E4E4E4_0000FFFF, ramp_walk(8'd255, 8'd0));
      send_block(64'h1B1B1B1B_FFFF0000, ramp_walk(8'd0, 8'd255));
      send_block(64'hE4E4E4E4_F81F07E0, ramp_walk(8'd128, 8'd128));
      send_block(64'h4E4E4E4E_001FF800, ramp_walk(8'd37, 8'd200));
      send_block('1, '1);
      send_block('0, '0);

      // clipped edge blocks, starting from a position outside the new grid
      configure(1'b0, 13'd6, 13'd5);
      repeat (5) send_block(random_color(), {$urandom, $urandom});

      // zero size counts as one pixel
      configure(1'b1, 13'd0, 13'd0);
      repeat (3) send_block(random_color(), {$urandom, $urandom});

      // oversize clamps to the maximum
      configure(1'b0, 13'h1fff, 13'd4097);
      repeat (2) send_block(random_color(), {$urandom, $urandom});

      first_phase = 1'b1;
      texel_blocks = 0;
      while (texel_blocks < RANDOM_BLOCKS) begin
         if ($urandom_range(0, 2) == 0)
            configure(1'($urandom_range(0, 1)), pick_size(), pick_size());
         else
            configure(1'($urandom_range(0, 1)), DIM_W'($urandom_range(1, 24)),
                      DIM_W'($urandom_range(1, 24)));
         // long receiver stall so the decoder fills and backs up its input
         if (first_phase) hold_req = 1'b1;
         first_phase = 1'b0;
         count = $urandom_range(10, 40);
         repeat (count) send_block(random_color(), {$urandom, $urandom});
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: dxt1_dxt5_block_decoder.f
rtl/core/dxt_pkg.sv
rtl/core/dxt_if.sv
rtl/core/dxt_front.sv
rtl/core/dxt_queue.sv
rtl/core/dxt_back.sv
rtl/core/dxt1_dxt5_block_decoder.sv
dv/tb_dxt1_dxt5_block_decoder.sv
